[rtl/ppm_pkg.sv]
// Package with the word types, operation and register codes, and default sizes of the pixel mixer.
package ppm_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [2:0] {
        OP_PIXEL       = 3'd0,
        OP_LOAD_RIPPLE = 3'd1,
        OP_LOAD_SPIRAL = 3'd2,
        OP_END_FRAME   = 3'd3,
        OP_RESTART     = 3'd4
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_COLOR_MASK   = 3'd2,
        CFG_RED_START_X  = 3'd3,
        CFG_RED_START_Y  = 3'd4,
        CFG_BLUE_START_X = 3'd5,
        CFG_BLUE_START_Y = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [7:0]  in_alpha;
        logic [17:0] table_index;
        logic [7:0]  table_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } out_word_t;

    typedef struct packed {
        logic rd_en;
        logic ripple_we;
        logic spiral_we;
    } mem_ctl_t;

endpackage

[rtl/ppm_pattern_mem.sv]
// Ripple and spiral pattern memories with one write port and registered read ports.
module ppm_pattern_mem #(
    parameter int unsigned MAX_WIDTH  = ppm_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = ppm_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned RIP_AW     = $clog2(4 * MAX_WIDTH * MAX_HEIGHT),
    parameter int unsigned SP_AW      = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic              aclk,
    input  ppm_pkg::mem_ctl_t ctl,
    input  logic [RIP_AW-1:0] ripple_waddr,
    input  logic [SP_AW-1:0]  spiral_waddr,
    input  logic [7:0]        wdata,
    input  logic [RIP_AW-1:0] red_raddr,
    input  logic [RIP_AW-1:0] blue_raddr,
    input  logic [SP_AW-1:0]  spiral_raddr,
    output logic [7:0]        red_rdata,
    output logic [7:0]        blue_rdata,
    output logic [7:0]        spiral_rdata
);
    import ppm_pkg::*;

    localparam int unsigned RIP_DEPTH = 4 * MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned SP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

    logic [7:0] ripple_mem [RIP_DEPTH];
    logic [7:0] spiral_mem [SP_DEPTH];

    logic [7:0] red_rdata_reg;
    logic [7:0] blue_rdata_reg;
    logic [7:0] spiral_rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ripple_we) begin
            ripple_mem[ripple_waddr] <= wdata;
        end
        if (ctl.rd_en) begin
            red_rdata_reg  <= ripple_mem[red_raddr];
            blue_rdata_reg <= ripple_mem[blue_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.spiral_we) begin
            spiral_mem[spiral_waddr] <= wdata;
        end
        if (ctl.rd_en) begin
            spiral_rdata_reg <= spiral_mem[spiral_raddr];
        end
    end

    assign red_rdata    = red_rdata_reg;
    assign blue_rdata   = blue_rdata_reg;
    assign spiral_rdata = spiral_rdata_reg;

endmodule

[rtl/psychedelic_pattern_pixel_mixer_unit.sv]
// Top level of the pixel mixer: command decode, position state and the output pipeline.
//
//   Port group   Direction  Handshake          Carries
//   s_*          in         s_valid / s_ready  pixel, table load, end frame, restart
//   m_*          out        m_valid / m_ready  one mixed pixel per pixel word
//   cfg_*        in         cfg_we             frame size, color mask, start positions
//
// One word is accepted every cycle while s_ready is high; a pixel passes the table-read register
// and then the output register before it appears on m_*.
// The three table reads use two read ports of the ripple memory and one of the spiral memory.
// Reset clears positions, phase and the pipeline, presets direction and cfg; tables are left as they are.
// A stall on m_ready holds the pipeline, and s_ready drops only when both stages are full.
module psychedelic_pattern_pixel_mixer_unit #(
    parameter int unsigned MAX_WIDTH  = ppm_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = ppm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ppm_pkg::in_word_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ppm_pkg::out_word_t                 m_data,
    input  logic                               cfg_we,
    input  logic [ppm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ppm_pkg::*;

    localparam int unsigned RIP_PITCH = 2 * MAX_WIDTH;
    localparam int unsigned RIP_ROWS  = 2 * MAX_HEIGHT;
    localparam int unsigned RIP_DEPTH = RIP_PITCH * RIP_ROWS;
    localparam int unsigned SP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned RIP_AW    = $clog2(RIP_DEPTH);
    localparam int unsigned SP_AW     = $clog2(SP_DEPTH);

    // Moves one coordinate by two, bouncing at the frame edges; returns {direction, position}.
    function automatic logic [8:0] bounce(input logic [7:0] pos, input logic dir,
                                          input logic [8:0] frame);
        logic [8:0] size;
        logic [9:0] trial;
        logic       nd;
        logic [7:0] np;
        size  = (frame > 9'd256) ? 9'd256 : frame;
        trial = {2'b00, pos} + (dir ? 10'h3FE : 10'd2);
        nd    = dir;
        if (trial[9]) begin
            nd = 1'b0;
        end else if (trial >= {1'b0, size}) begin
            nd = 1'b1;
        end
        np = pos + (nd ? 8'hFE : 8'd2);
        return {nd, np};
    endfunction

    logic [8:0]  frame_width_reg;
    logic [8:0]  frame_height_reg;
    logic [23:0] color_mask_reg;
    logic [7:0]  red_start_x_reg;
    logic [7:0]  red_start_y_reg;
    logic [7:0]  blue_start_x_reg;
    logic [7:0]  blue_start_y_reg;

    logic [7:0]  red_pos_x_reg, red_pos_x_next;
    logic [7:0]  red_pos_y_reg, red_pos_y_next;
    logic [7:0]  blue_pos_x_reg, blue_pos_x_next;
    logic [7:0]  blue_pos_y_reg, blue_pos_y_next;
    logic [3:0]  dir_reg, dir_next;
    logic [7:0]  phase_reg, phase_next;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_red_on_reg, s1_green_on_reg, s1_blue_on_reg;
    logic        s1_red_ok_reg, s1_green_ok_reg, s1_blue_ok_reg;
    logic [7:0]  s1_alpha_reg;
    logic [7:0]  s1_phase_reg;

    logic        m_valid_reg, m_valid_next;
    out_word_t   m_data_reg, m_data_next;

    logic        advance;
    logic        accept;
    logic        is_pixel;
    mem_ctl_t    mem_ctl;

    logic [8:0]  red_row, red_col, blue_row, blue_col;
    logic        red_ok, blue_ok, green_ok;
    logic [31:0] red_addr_full, blue_addr_full, spiral_addr_full, index_full;
    logic [RIP_AW-1:0] red_raddr, blue_raddr, ripple_waddr;
    logic [SP_AW-1:0]  spiral_raddr, spiral_waddr;
    logic [7:0]  red_rdata, blue_rdata, spiral_rdata;

    logic [8:0]  rx_b, ry_b, bx_b, by_b;
    logic [7:0]  red_sum, green_sum, blue_sum;
    logic [7:0]  red_byte, green_byte, blue_byte;

    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || advance;
    assign accept   = s_valid && s_ready;
    assign is_pixel = (s_data.operation == OP_PIXEL);

    // Table addressing; reads beyond the table extent are flagged and forced to zero later.
    assign red_row  = {1'b0, s_data.pixel_y} + {1'b0, red_pos_y_reg};
    assign red_col  = {1'b0, s_data.pixel_x} + {1'b0, red_pos_x_reg};
    assign blue_row = {1'b0, s_data.pixel_y} + {1'b0, blue_pos_y_reg};
    assign blue_col = {1'b0, s_data.pixel_x} + {1'b0, blue_pos_x_reg};
    assign red_ok   = (32'(red_row) < RIP_ROWS) && (32'(red_col) < RIP_PITCH);
    assign blue_ok  = (32'(blue_row) < RIP_ROWS) && (32'(blue_col) < RIP_PITCH);
    assign green_ok = (32'(s_data.pixel_y) < MAX_HEIGHT) && (32'(s_data.pixel_x) < MAX_WIDTH);

    assign red_addr_full    = 32'(red_row) * RIP_PITCH + 32'(red_col);
    assign blue_addr_full   = 32'(blue_row) * RIP_PITCH + 32'(blue_col);
    assign spiral_addr_full = 32'(s_data.pixel_y) * MAX_WIDTH + 32'(s_data.pixel_x);
    assign index_full       = 32'(s_data.table_index);

    assign red_raddr    = red_addr_full[RIP_AW-1:0];
    assign blue_raddr   = blue_addr_full[RIP_AW-1:0];
    assign spiral_raddr = spiral_addr_full[SP_AW-1:0];
    assign ripple_waddr = index_full[RIP_AW-1:0];
    assign spiral_waddr = index_full[SP_AW-1:0];

    always_comb begin
        mem_ctl.rd_en     = accept && is_pixel;
        mem_ctl.ripple_we = accept && (s_data.operation == OP_LOAD_RIPPLE)
                            && (index_full < RIP_DEPTH);
        mem_ctl.spiral_we = accept && (s_data.operation == OP_LOAD_SPIRAL)
                            && (index_full < SP_DEPTH);
    end

    ppm_pattern_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RIP_AW     (RIP_AW),
        .SP_AW      (SP_AW)
    ) u_mem (
        .aclk         (aclk),
        .ctl          (mem_ctl),
        .ripple_waddr (ripple_waddr),
        .spiral_waddr (spiral_waddr),
        .wdata        (s_data.table_value),
        .red_raddr    (red_raddr),
        .blue_raddr   (blue_raddr),
        .spiral_raddr (spiral_raddr),
        .red_rdata    (red_rdata),
        .blue_rdata   (blue_rdata),
        .spiral_rdata (spiral_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 9'd256;
            frame_height_reg <= 9'd256;
            color_mask_reg   <= 24'hFFFFFF;
            red_start_x_reg  <= '0;
            red_start_y_reg  <= '0;
            blue_start_x_reg <= '0;
            blue_start_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[8:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[8:0];
                CFG_COLOR_MASK:   color_mask_reg   <= cfg_wdata[23:0];
                CFG_RED_START_X:  red_start_x_reg  <= cfg_wdata[7:0];
                CFG_RED_START_Y:  red_start_y_reg  <= cfg_wdata[7:0];
                CFG_BLUE_START_X: blue_start_x_reg <= cfg_wdata[7:0];
                CFG_BLUE_START_Y: blue_start_y_reg <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign rx_b = bounce(red_pos_x_reg, dir_reg[0], frame_width_reg);
    assign ry_b = bounce(red_pos_y_reg, dir_reg[1], frame_height_reg);
    assign bx_b = bounce(blue_pos_x_reg, dir_reg[2], frame_width_reg);
    assign by_b = bounce(blue_pos_y_reg, dir_reg[3], frame_height_reg);

    always_comb begin
        red_pos_x_next  = red_pos_x_reg;
        red_pos_y_next  = red_pos_y_reg;
        blue_pos_x_next = blue_pos_x_reg;
        blue_pos_y_next = blue_pos_y_reg;
        dir_next        = dir_reg;
        phase_next      = phase_reg;
        if (accept) begin
            case (s_data.operation)
                OP_END_FRAME: begin
                    phase_next      = phase_reg - 8'd8;
                    red_pos_x_next  = rx_b[7:0];
                    red_pos_y_next  = ry_b[7:0];
                    blue_pos_x_next = bx_b[7:0];
                    blue_pos_y_next = by_b[7:0];
                    dir_next        = {by_b[8], bx_b[8], ry_b[8], rx_b[8]};
                end
                OP_RESTART: begin
                    red_pos_x_next  = red_start_x_reg;
                    red_pos_y_next  = red_start_y_reg;
                    blue_pos_x_next = blue_start_x_reg;
                    blue_pos_y_next = blue_start_y_reg;
                    dir_next        = 4'b0011;
                    phase_next      = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_pos_x_reg  <= '0;
            red_pos_y_reg  <= '0;
            blue_pos_x_reg <= '0;
            blue_pos_y_reg <= '0;
            dir_reg        <= 4'b0011;
            phase_reg      <= '0;
        end else begin
            red_pos_x_reg  <= red_pos_x_next;
            red_pos_y_reg  <= red_pos_y_next;
            blue_pos_x_reg <= blue_pos_x_next;
            blue_pos_y_reg <= blue_pos_y_next;
            dir_reg        <= dir_next;
            phase_reg      <= phase_next;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (advance) begin
            s1_valid_next = 1'b0;
        end
        if (accept && is_pixel) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_pixel) begin
            s1_red_on_reg   <= s_data.in_red[7];
            s1_green_on_reg <= s_data.in_green[7];
            s1_blue_on_reg  <= s_data.in_blue[7];
            s1_red_ok_reg   <= red_ok;
            s1_green_ok_reg <= green_ok;
            s1_blue_ok_reg  <= blue_ok;
            s1_alpha_reg    <= s_data.in_alpha;
            s1_phase_reg    <= phase_reg;
        end
    end

    assign red_byte   = s1_red_ok_reg ? red_rdata : 8'd0;
    assign green_byte = s1_green_ok_reg ? spiral_rdata : 8'd0;
    assign blue_byte  = s1_blue_ok_reg ? blue_rdata : 8'd0;
    assign red_sum    = red_byte + {s1_phase_reg[6:0], 1'b0};
    assign green_sum  = green_byte + {s1_phase_reg[6:0], 1'b0} + s1_phase_reg;
    assign blue_sum   = blue_byte - s1_phase_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next = s1_valid_reg;
            m_data_next.out_red   = (s1_red_on_reg && red_sum[7]) ? color_mask_reg[23:16] : 8'd0;
            m_data_next.out_green = (s1_green_on_reg && green_sum[7]) ? color_mask_reg[15:8]
                                                                      : 8'd0;
            m_data_next.out_blue  = (s1_blue_on_reg && blue_sum[7]) ? color_mask_reg[7:0] : 8'd0;
            m_data_next.out_alpha = s1_alpha_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
